// ===== rtl/tnpm_pkg.sv =====
// Shared types, codes and default sizes for the ternary neighbour pattern match block.
package tnpm_pkg;

    // Default table geometry.
    localparam int ROWS_PER_GROUP_DEF = 64;
    localparam int GROUP_COUNT_DEF    = 11;

    // Fixed neighbourhood and field sizes.
    localparam int NEIGHBORS    = 8;
    localparam int CODE_W       = 2;
    localparam int PATTERN_W    = NEIGHBORS * CODE_W;
    localparam int ORIENT_SLOTS = 4;
    localparam int BYTE_W       = 8;
    localparam int OFFSETS_W    = ORIENT_SLOTS * BYTE_W;
    localparam int GROUP_SEL_W  = 4;
    localparam int ORIENT_W     = 3;
    localparam int SLOT_W       = 2;

    // Stored row layout: pattern, orientation offsets, canal offset, variant count.
    localparam int ROW_W        = PATTERN_W + OFFSETS_W + 2 * BYTE_W;
    localparam int OFFSETS_LSB  = PATTERN_W;
    localparam int CANAL_LSB    = PATTERN_W + OFFSETS_W;
    localparam int VARIANTS_LSB = CANAL_LSB + BYTE_W;

    // Neighbour codes: must be clear, must be set, either state, never matches.
    localparam logic [CODE_W-1:0] CODE_MATCH_0   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_MATCH_1   = 2'd1;
    localparam logic [CODE_W-1:0] CODE_DONT_CARE = 2'd2;
    localparam logic [CODE_W-1:0] CODE_NEVER     = 2'd3;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_CLEAR     = 2'd0,
        REQ_APPEND    = 2'd1,
        REQ_LOOKUP    = 2'd2,
        REQ_RESET_CNT = 2'd3
    } req_t;

endpackage

// ===== rtl/tnpm_row_match.sv =====
// Ternary compare of one stored row pattern against a neighbour mask.
module tnpm_row_match
(
    input  logic [tnpm_pkg::PATTERN_W-1:0] pattern,
    input  logic [tnpm_pkg::NEIGHBORS-1:0] mask,
    output logic                           hit
);

    logic [tnpm_pkg::NEIGHBORS-1:0] lane_ok;

    // Each neighbour matches on a don't care code or on a code equal to its bit.
    // The never code cannot equal a single bit, so it always fails.
    always_comb
    begin
        for (int i = 0; i < tnpm_pkg::NEIGHBORS; i++)
        begin
            lane_ok[i] = (pattern[i*tnpm_pkg::CODE_W +: tnpm_pkg::CODE_W]
                          == tnpm_pkg::CODE_DONT_CARE)
                      || (pattern[i*tnpm_pkg::CODE_W +: tnpm_pkg::CODE_W]
                          == {1'b0, mask[i]});
        end
    end

    assign hit = &lane_ok;

endmodule

// ===== rtl/ternary_neighbor_pattern_match.sv =====
// Top level of the first-match ternary neighbour pattern table.
//
// Request words arrive on req_valid/req_stall with their fields on separate ports;
// one result word per request leaves on res_valid/res_stall. A word moves at a
// rising edge where valid is high and stall is low.
// Requests are handled one at a time. A clear passes straight to the result
// register, an append first writes its row (not when the group is full), a counter
// reset first zeroes the counter of each row held by the group, and a lookup
// reads one row per cycle from the row memory through a single shared ternary
// comparator and stops at the first hit.
// A new request is taken in the cycle after a result is loaded.
// The result sits in an output register; while the receiver stalls, the block
// still accepts and processes the next request and holds its result until the
// output register frees.
// Reset empties every group and clears the handshake state. The row memories are
// not cleared: only appended rows are ever read, and an append also zeroes the
// row's variant counter, so no clearing pass is needed.
module ternary_neighbor_pattern_match
#(
    parameter int ROWS_PER_GROUP = tnpm_pkg::ROWS_PER_GROUP_DEF,
    parameter int GROUP_COUNT    = tnpm_pkg::GROUP_COUNT_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [1:0]                           req_type,
    input  logic [tnpm_pkg::GROUP_SEL_W-1:0]     group_sel,
    input  logic [tnpm_pkg::NEIGHBORS-1:0]       neighbor_mask,
    input  logic [tnpm_pkg::ORIENT_W-1:0]        view_orientation,
    input  logic [tnpm_pkg::PATTERN_W-1:0]       row_pattern,
    input  logic [tnpm_pkg::OFFSETS_W-1:0]       row_orient_offsets,
    input  logic [tnpm_pkg::BYTE_W-1:0]          row_canal_offset,
    input  logic [tnpm_pkg::BYTE_W-1:0]          row_variants,

    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic                                 match_valid,
    output logic [tnpm_pkg::BYTE_W-1:0]          orient_ofs,
    output logic [tnpm_pkg::BYTE_W-1:0]          variant_idx,
    output logic [tnpm_pkg::BYTE_W-1:0]          canal_ofs,
    output logic                                 status
);

    localparam int DEPTH = GROUP_COUNT * ROWS_PER_GROUP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(ROWS_PER_GROUP + 1);
    localparam int GIW   = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int BW    = tnpm_pkg::BYTE_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WRITE = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_WAIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Per-group row counts.
    logic [CW-1:0] rows_reg [GROUP_COUNT];

    // Request latched at acceptance.
    logic [GIW-1:0]                     grp_map;
    logic [CW-1:0]                      n_in;
    logic                               full_in;
    logic                               accept;
    tnpm_pkg::req_t                     req_in;
    logic [AW-1:0]                      base_reg;
    logic [CW-1:0]                      n_reg;
    logic [tnpm_pkg::NEIGHBORS-1:0]     mask_reg;
    logic [tnpm_pkg::SLOT_W-1:0]        slot_reg;
    logic [tnpm_pkg::ROW_W-1:0]         wdata_reg;

    // Scan sequencer.
    logic [CW-1:0]                      r_reg, r_next;
    logic [AW-1:0]                      cur_addr;
    logic                               issue;
    logic                               rd_vld_reg;
    logic [AW-1:0]                      rd_addr_reg;
    logic [tnpm_pkg::ROW_W-1:0]         row_q;
    logic [BW-1:0]                      cnt_q;
    logic                               row_hit;
    logic                               hit;
    logic [BW-1:0]                      c_inc;
    logic [BW-1:0]                      c_new;

    // Memory write controls.
    logic                               row_we;
    logic                               cnt_we;
    logic [AW-1:0]                      cnt_waddr;
    logic [BW-1:0]                      cnt_wdata;

    // Memories.
    logic [tnpm_pkg::ROW_W-1:0]         row_mem [DEPTH];
    logic [BW-1:0]                      cnt_mem [DEPTH];

    // Staged result and output register.
    logic                               st_match_reg, st_match_next;
    logic [BW-1:0]                      st_goff_reg, st_goff_next;
    logic [BW-1:0]                      st_ioff_reg, st_ioff_next;
    logic [BW-1:0]                      st_coff_reg, st_coff_next;
    logic                               st_status_reg, st_status_next;
    logic                               out_load;
    logic                               res_valid_reg, res_valid_next;

    // Group decode: an out-of-range group addresses group 0.
    assign grp_map = ({1'b0, group_sel} >= (tnpm_pkg::GROUP_SEL_W + 1)'(GROUP_COUNT))
                   ? '0 : GIW'(group_sel);
    assign n_in    = rows_reg[grp_map];
    assign full_in = (n_in >= CW'(ROWS_PER_GROUP));
    assign req_in  = tnpm_pkg::req_t'(req_type);
    assign accept  = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);

    assign cur_addr = base_reg + AW'(r_reg);

    // Shared ternary comparator working on the registered row read.
    tnpm_row_match u_match
    (
        .pattern (row_q[tnpm_pkg::PATTERN_W-1:0]),
        .mask    (mask_reg),
        .hit     (row_hit)
    );

    assign hit   = (state_reg == ST_SCAN) && rd_vld_reg && row_hit;
    assign c_inc = cnt_q + BW'(1);
    assign c_new = (c_inc >= row_q[tnpm_pkg::VARIANTS_LSB +: BW]) ? '0 : c_inc;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        issue          = 1'b0;
        row_we         = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = cur_addr;
        cnt_wdata      = '0;
        out_load       = 1'b0;
        st_match_next  = st_match_reg;
        st_goff_next   = st_goff_reg;
        st_ioff_next   = st_ioff_reg;
        st_coff_next   = st_coff_reg;
        st_status_next = st_status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    st_match_next  = 1'b0;
                    st_goff_next   = '0;
                    st_ioff_next   = '0;
                    st_coff_next   = '0;
                    st_status_next = 1'b0;
                    r_next         = '0;
                    unique case (req_in)
                        tnpm_pkg::REQ_CLEAR:
                        begin
                            state_next = ST_WAIT;
                        end
                        tnpm_pkg::REQ_APPEND:
                        begin
                            st_status_next = full_in;
                            r_next         = n_in;
                            state_next     = full_in ? ST_WAIT : ST_WRITE;
                        end
                        tnpm_pkg::REQ_LOOKUP:
                        begin
                            state_next = ST_SCAN;
                        end
                        tnpm_pkg::REQ_RESET_CNT:
                        begin
                            state_next = ST_SWEEP;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                // New row lands at the end of the group with its counter at zero.
                row_we     = 1'b1;
                cnt_we     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_SCAN:
            begin
                priority if (hit)
                begin
                    cnt_we        = 1'b1;
                    cnt_waddr     = rd_addr_reg;
                    cnt_wdata     = c_new;
                    st_match_next = 1'b1;
                    st_goff_next  = row_q[tnpm_pkg::OFFSETS_LSB + BW * slot_reg +: BW];
                    st_ioff_next  = c_new;
                    st_coff_next  = row_q[tnpm_pkg::CANAL_LSB +: BW];
                    state_next    = ST_WAIT;
                end
                else if (r_reg < n_reg)
                begin
                    issue  = 1'b1;
                    r_next = r_reg + CW'(1);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_SWEEP:
            begin
                // Only appended rows can be read later, so only those are zeroed.
                if (r_reg < n_reg)
                begin
                    cnt_we = 1'b1;
                    r_next = r_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid_next = out_load || (res_valid_reg && res_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                rows_reg[g] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= issue;
            res_valid_reg <= res_valid_next;
            if (accept && (req_in == tnpm_pkg::REQ_CLEAR))
            begin
                rows_reg[grp_map] <= '0;
            end
            else if (accept && (req_in == tnpm_pkg::REQ_APPEND) && !full_in)
            begin
                rows_reg[grp_map] <= n_in + CW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        r_reg          <= r_next;
        st_match_reg   <= st_match_next;
        st_goff_reg    <= st_goff_next;
        st_ioff_reg    <= st_ioff_next;
        st_coff_reg    <= st_coff_next;
        st_status_reg  <= st_status_next;
        if (accept)
        begin
            base_reg  <= AW'(grp_map * ROWS_PER_GROUP);
            n_reg     <= n_in;
            mask_reg  <= neighbor_mask;
            slot_reg  <= view_orientation[tnpm_pkg::ORIENT_W-1:1];
            wdata_reg <= {row_variants, row_canal_offset, row_orient_offsets, row_pattern};
        end
        if (issue)
        begin
            rd_addr_reg <= cur_addr;
        end
        if (out_load)
        begin
            match_valid <= st_match_reg;
            orient_ofs  <= st_goff_reg;
            variant_idx <= st_ioff_reg;
            canal_ofs   <= st_coff_reg;
            status      <= st_status_reg;
        end
    end

    // Row memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[cur_addr] <= wdata_reg;
        end
        if (issue)
        begin
            row_q <= row_mem[cur_addr];
        end
    end

    // Variant counter memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (issue)
        begin
            cnt_q <= cnt_mem[cur_addr];
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// ===== tb/sv/tb_ternary_neighbor_pattern_match.sv =====
// Self-checking testbench for the ternary neighbour pattern match block, with its own table predictor.
module tb_ternary_neighbor_pattern_match;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS       = tnpm_pkg::ROWS_PER_GROUP_DEF;
    localparam int GROUPS     = tnpm_pkg::GROUP_COUNT_DEF;
    localparam int DEPTH      = ROWS * GROUPS;
    localparam int WORD_TOTAL = 850;

    localparam int NEIGHBORS   = tnpm_pkg::NEIGHBORS;
    localparam int CODE_W      = tnpm_pkg::CODE_W;
    localparam int PATTERN_W   = tnpm_pkg::PATTERN_W;
    localparam int OFFSETS_W   = tnpm_pkg::OFFSETS_W;
    localparam int BYTE_W      = tnpm_pkg::BYTE_W;
    localparam int GROUP_SEL_W = tnpm_pkg::GROUP_SEL_W;
    localparam int ORIENT_W    = tnpm_pkg::ORIENT_W;
    localparam int SLOT_W      = tnpm_pkg::SLOT_W;

    // One request word as it sits on the input ports.
    typedef struct {
        tnpm_pkg::req_t       kind;
        logic [GROUP_SEL_W-1:0] grp;
        logic [NEIGHBORS-1:0] mask;
        logic [ORIENT_W-1:0]  orient;
        logic [PATTERN_W-1:0] pattern;
        logic [OFFSETS_W-1:0] offsets;
        logic [BYTE_W-1:0]    canal;
        logic [BYTE_W-1:0]    variants;
    } tile_request_t;

    // One answer word as it leaves the block.
    typedef struct {
        logic              hit;
        logic [BYTE_W-1:0] goff;
        logic [BYTE_W-1:0] ioff;
        logic [BYTE_W-1:0] coff;
        logic              dropped;
    } tile_answer_t;

    logic                   clk                = 1'b0;
    logic                   rst_n              = 1'b0;
    logic                   req_valid          = 1'b0;
    logic                   req_stall;
    logic [1:0]             req_type           = '0;
    logic [GROUP_SEL_W-1:0] group_sel          = '0;
    logic [NEIGHBORS-1:0]   neighbor_mask      = '0;
    logic [ORIENT_W-1:0]    view_orientation   = '0;
    logic [PATTERN_W-1:0]   row_pattern        = '0;
    logic [OFFSETS_W-1:0]   row_orient_offsets = '0;
    logic [BYTE_W-1:0]      row_canal_offset   = '0;
    logic [BYTE_W-1:0]      row_variants       = '0;
    logic                   res_valid;
    logic                   res_stall          = 1'b0;
    logic                   match_valid;
    logic [BYTE_W-1:0]      orient_ofs;
    logic [BYTE_W-1:0]      variant_idx;
    logic [BYTE_W-1:0]      canal_ofs;
    logic                   status;

    ternary_neighbor_pattern_match u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .req_type           (req_type),
        .group_sel          (group_sel),
        .neighbor_mask      (neighbor_mask),
        .view_orientation   (view_orientation),
        .row_pattern        (row_pattern),
        .row_orient_offsets (row_orient_offsets),
        .row_canal_offset   (row_canal_offset),
        .row_variants       (row_variants),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .match_valid        (match_valid),
        .orient_ofs         (orient_ofs),
        .variant_idx        (variant_idx),
        .canal_ofs          (canal_ofs),
        .status             (status)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predicted copy of the pattern tables.
    logic [PATTERN_W-1:0] tile_code_tbl   [DEPTH];
    logic [OFFSETS_W-1:0] tile_offset_tbl [DEPTH];
    logic [BYTE_W-1:0]    tile_canal_tbl  [DEPTH];
    logic [BYTE_W-1:0]    tile_limit_tbl  [DEPTH];
    logic [BYTE_W-1:0]    tile_count_tbl  [DEPTH] = '{default: '0};
    int unsigned          tile_rows       [GROUPS] = '{default: 0};

    // Patterns queued so far, per group, so that lookups can be aimed at stored rows.
    logic [PATTERN_W-1:0] planned_pat  [GROUPS][ROWS];
    int unsigned          planned_rows [GROUPS] = '{default: 0};

    tile_request_t word_queue[$];
    tile_answer_t  tile_answers_due[$];
    tile_request_t cur_word;
    int            error_count = 0;
    int            answers_seen = 0;
    int            gap_left = 0;
    int            burst_left = 0;
    int            stall_mode = 0;
    int            stall_phase_left = 0;
    int            stall_hold_left = 0;

    // A pattern hits when every neighbour code is either don't care or equal to the mask bit.
    function automatic bit pattern_hits(logic [PATTERN_W-1:0] pat, logic [NEIGHBORS-1:0] mask);
        logic [CODE_W-1:0] code;
        bit                ok;
        ok = 1'b1;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            code = pat[CODE_W*i +: CODE_W];
            if (code != tnpm_pkg::CODE_DONT_CARE && code != {1'b0, mask[i]})
                ok = 1'b0;
        end
        return ok;
    endfunction

    // Applies one request to the predicted tables and returns the answer it should give.
    function automatic tile_answer_t resolve_tile_request(tile_request_t rq);
        tile_answer_t      ans;
        int unsigned       g;
        int unsigned       base;
        int unsigned       n;
        int unsigned       idx;
        logic [BYTE_W-1:0] cnt;
        logic [SLOT_W-1:0] slot;
        ans = '{hit: 1'b0, goff: '0, ioff: '0, coff: '0, dropped: 1'b0};
        g = (rq.grp >= GROUPS) ? 0 : rq.grp;
        base = g * ROWS;
        n = tile_rows[g];
        case (rq.kind)
            tnpm_pkg::REQ_CLEAR:
                tile_rows[g] = 0;
            tnpm_pkg::REQ_APPEND:
            begin
                if (n >= ROWS)
                    ans.dropped = 1'b1;
                else
                begin
                    idx = base + n;
                    tile_code_tbl[idx]   = rq.pattern;
                    tile_offset_tbl[idx] = rq.offsets;
                    tile_canal_tbl[idx]  = rq.canal;
                    tile_limit_tbl[idx]  = rq.variants;
                    tile_count_tbl[idx]  = '0;
                    tile_rows[g] = n + 1;
                end
            end
            tnpm_pkg::REQ_LOOKUP:
            begin
                for (int r = 0; r < n; r++)
                begin
                    idx = base + r;
                    if (!ans.hit && pattern_hits(tile_code_tbl[idx], rq.mask))
                    begin
                        cnt = tile_count_tbl[idx] + 8'd1;
                        if (cnt >= tile_limit_tbl[idx])
                            cnt = '0;
                        tile_count_tbl[idx] = cnt;
                        slot = rq.orient[ORIENT_W-1:1];
                        ans.hit  = 1'b1;
                        ans.goff = tile_offset_tbl[idx][BYTE_W*slot +: BYTE_W];
                        ans.ioff = cnt;
                        ans.coff = tile_canal_tbl[idx];
                    end
                end
            end
            default:
            begin
                for (int r = 0; r < ROWS; r++)
                    tile_count_tbl[base + r] = '0;
            end
        endcase
        return ans;
    endfunction

    // Random pattern weighted towards don't care so that lookups hit often.
    function automatic logic [PATTERN_W-1:0] draw_pattern();
        logic [PATTERN_W-1:0] pat;
        int unsigned          pick;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                pat[CODE_W*i +: CODE_W] = tnpm_pkg::CODE_DONT_CARE;
            else if (pick < 7)
                pat[CODE_W*i +: CODE_W] = tnpm_pkg::CODE_MATCH_0;
            else if (pick < 9)
                pat[CODE_W*i +: CODE_W] = tnpm_pkg::CODE_MATCH_1;
            else
                pat[CODE_W*i +: CODE_W] = tnpm_pkg::CODE_NEVER;
        end
        return pat;
    endfunction

    // Variant counts: mostly small so that counters wrap, sometimes the extremes.
    function automatic logic [BYTE_W-1:0] draw_variants();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return BYTE_W'($urandom_range(0, 4));
        else if (pick == 6)
            return 8'hFF;
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Group selector: mostly in range, sometimes out of range.
    function automatic logic [GROUP_SEL_W-1:0] draw_group();
        if ($urandom_range(0, 4) == 0)
            return GROUP_SEL_W'($urandom_range(GROUPS, 15));
        return GROUP_SEL_W'($urandom_range(0, GROUPS - 1));
    endfunction

    // A mask that satisfies the given pattern wherever that is possible.
    function automatic logic [NEIGHBORS-1:0] mask_hitting(logic [PATTERN_W-1:0] pat);
        logic [NEIGHBORS-1:0] mask;
        mask = NEIGHBORS'($urandom_range(0, 255));
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            if (pat[CODE_W*i +: CODE_W] == tnpm_pkg::CODE_MATCH_0)
                mask[i] = 1'b0;
            else if (pat[CODE_W*i +: CODE_W] == tnpm_pkg::CODE_MATCH_1)
                mask[i] = 1'b1;
        end
        return mask;
    endfunction

    // A word of the given kind and group, with every other field random.
    function automatic tile_request_t scramble_word(tnpm_pkg::req_t kind,
                                                    logic [GROUP_SEL_W-1:0] grp);
        tile_request_t w;
        w.kind     = kind;
        w.grp      = grp;
        w.mask     = NEIGHBORS'($urandom_range(0, 255));
        w.orient   = ORIENT_W'($urandom_range(0, 7));
        w.pattern  = PATTERN_W'($urandom_range(0, 65535));
        w.offsets  = OFFSETS_W'($urandom);
        w.canal    = BYTE_W'($urandom_range(0, 255));
        w.variants = BYTE_W'($urandom_range(0, 255));
        return w;
    endfunction

    // Queue a word and keep track of which patterns each group will hold.
    task automatic queue_word(tile_request_t w);
        int unsigned g;
        g = (w.grp >= GROUPS) ? 0 : w.grp;
        if (w.kind == tnpm_pkg::REQ_CLEAR)
            planned_rows[g] = 0;
        else if (w.kind == tnpm_pkg::REQ_APPEND && planned_rows[g] < ROWS)
        begin
            planned_pat[g][planned_rows[g]] = w.pattern;
            planned_rows[g]++;
        end
        word_queue = {word_queue, w};
    endtask

    task automatic queue_append(logic [GROUP_SEL_W-1:0] grp, logic [PATTERN_W-1:0] pat,
                                logic [OFFSETS_W-1:0] offs, logic [BYTE_W-1:0] canal,
                                logic [BYTE_W-1:0] variants);
        tile_request_t w;
        w = scramble_word(tnpm_pkg::REQ_APPEND, grp);
        w.pattern  = pat;
        w.offsets  = offs;
        w.canal    = canal;
        w.variants = variants;
        queue_word(w);
    endtask

    task automatic queue_lookup(logic [GROUP_SEL_W-1:0] grp, logic [NEIGHBORS-1:0] mask,
                                logic [ORIENT_W-1:0] orient);
        tile_request_t w;
        w = scramble_word(tnpm_pkg::REQ_LOOKUP, grp);
        w.mask   = mask;
        w.orient = orient;
        queue_word(w);
    endtask

    // Count and print one mismatch.
    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("mismatch in %s at answer %0d: expected %0h, got %0h",
                 what, answers_seen, want, got);
        error_count++;
    endtask

    // Driver: sends queued words in bursts with random gaps, holding a word while stalled.
    always @(posedge clk)
    begin : drive_words
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
                tile_answers_due = {tile_answers_due, resolve_tile_request(cur_word)};
            if (!(req_valid && req_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (word_queue.size() > 0)
                begin
                    cur_word = word_queue.pop_front();
                    req_valid          <= 1'b1;
                    req_type           <= cur_word.kind;
                    group_sel          <= cur_word.grp;
                    neighbor_mask      <= cur_word.mask;
                    view_orientation   <= cur_word.orient;
                    row_pattern        <= cur_word.pattern;
                    row_orient_offsets <= cur_word.offsets;
                    row_canal_offset   <= cur_word.canal;
                    row_variants       <= cur_word.variants;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 11);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            9:       gap_left = $urandom_range(10, 30);
                            default: gap_left = $urandom_range(1, 5);
                        endcase
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Receiver pacing: phases of no stall, random stall, long holds and a regular pattern.
    always @(posedge clk)
    begin : pace_answers
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (stall_phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_phase_left = $urandom_range(20, 200);
            end
            else
                stall_phase_left--;
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 99) < 30);
                2:
                begin
                    if (stall_hold_left > 0)
                    begin
                        stall_hold_left--;
                        res_stall <= 1'b1;
                    end
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        stall_hold_left = $urandom_range(5, 40);
                        res_stall <= 1'b1;
                    end
                    else
                        res_stall <= 1'b0;
                end
                default: res_stall <= (stall_phase_left % 3 != 0);
            endcase
        end
    end

    // Monitor: each accepted answer word against the oldest prediction.
    always @(posedge clk)
    begin : check_answers
        tile_answer_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (tile_answers_due.size() == 0)
                report_mismatch("answer with nothing pending", 0, 1);
            else
            begin
                want = tile_answers_due.pop_front();
                if (match_valid !== want.hit)
                    report_mismatch("match_valid", want.hit, match_valid);
                if (orient_ofs !== want.goff)
                    report_mismatch("orient_ofs", want.goff, orient_ofs);
                if (variant_idx !== want.ioff)
                    report_mismatch("variant_idx", want.ioff, variant_idx);
                if (canal_ofs !== want.coff)
                    report_mismatch("canal_ofs", want.coff, canal_ofs);
                if (status !== want.dropped)
                    report_mismatch("status", want.dropped, status);
            end
            answers_seen++;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : run_stimulus
        int unsigned          pick;
        int unsigned          n;
        int unsigned          g;
        logic [GROUP_SEL_W-1:0] grp;
        logic [NEIGHBORS-1:0] mask;

        // Directed words: empty group, counter wrap, every orientation slot, extremes,
        // out-of-range groups, a scan past a failing row, never-matching codes, counter reset.
        queue_lookup(4'd0, 8'h00, 3'd0);
        queue_append(4'd0, 16'hAAAA, 32'h04030201, 8'hFF, 8'd3);
        queue_lookup(4'd0, 8'hFF, 3'd0);
        queue_lookup(4'd0, 8'h00, 3'd2);
        queue_lookup(4'd0, 8'h5A, 3'd5);
        queue_lookup(4'd0, 8'hA5, 3'd7);
        queue_append(4'd10, 16'h0000, 32'hFFFFFFFF, 8'h00, 8'd0);
        queue_lookup(4'd10, 8'h00, 3'd6);
        queue_lookup(4'd10, 8'h01, 3'd1);
        queue_append(4'd15, 16'h5555, 32'h00000000, 8'h80, 8'hFF);
        queue_lookup(4'd12, 8'hFF, 3'd7);
        queue_append(4'd5, 16'hFFFF, 32'h12345678, 8'h11, 8'd2);
        queue_lookup(4'd5, 8'hC3, 3'd3);
        queue_append(4'd5, 16'h5555, 32'h89ABCDEF, 8'h22, 8'd2);
        queue_lookup(4'd5, 8'hFF, 3'd4);
        queue_word(scramble_word(tnpm_pkg::REQ_RESET_CNT, 4'd0));
        queue_lookup(4'd0, 8'h3C, 3'd1);
        queue_word(scramble_word(tnpm_pkg::REQ_CLEAR, 4'd11));
        queue_lookup(4'd0, 8'hFF, 3'd0);
        queue_word(scramble_word(tnpm_pkg::REQ_CLEAR, 4'd10));
        queue_lookup(4'd10, 8'h00, 3'd0);

        // Random sequences: table fills (some past full), aimed lookups, resets and noise.
        while (word_queue.size() < WORD_TOTAL)
        begin
            pick = $urandom_range(0, 99);
            grp = draw_group();
            g = (grp >= GROUPS) ? 0 : grp;
            if (pick < 15)
            begin
                queue_word(scramble_word(tnpm_pkg::REQ_CLEAR, grp));
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(ROWS, ROWS + 6);
                else
                    n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    queue_append(grp, draw_pattern(), OFFSETS_W'($urandom),
                                 BYTE_W'($urandom_range(0, 255)), draw_variants());
            end
            else if (pick < 70)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    if (planned_rows[g] > 0 && $urandom_range(0, 9) < 7)
                        mask = mask_hitting(
                            planned_pat[g][$urandom_range(0, planned_rows[g] - 1)]);
                    else
                        mask = NEIGHBORS'($urandom_range(0, 255));
                    queue_lookup(grp, mask, ORIENT_W'($urandom_range(0, 7)));
                end
            end
            else if (pick < 78)
                queue_word(scramble_word(tnpm_pkg::REQ_RESET_CNT, grp));
            else if (pick < 85)
                queue_append(grp, draw_pattern(), OFFSETS_W'($urandom),
                             BYTE_W'($urandom_range(0, 255)), draw_variants());
            else
                queue_word(scramble_word(tnpm_pkg::req_t'($urandom_range(0, 3)),
                                         GROUP_SEL_W'($urandom_range(0, 15))));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every answer to come out, then let things settle.
        while (word_queue.size() != 0 || req_valid || tile_answers_due.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
